// ----- src/vdhf_pkg.sv -----
// ----------------------------------------------------------------------------
// vdhf_pkg: shared types and constants of the voxel density histogram filter
// Field types, configuration register indexes, grid geometry and the internal
// request that passes from the quantizer to the count store.
// ----------------------------------------------------------------------------
package vdhf_pkg;

	localparam int GRID_X_MAX  = 128;
	localparam int GRID_Y_MAX  = 64;
	localparam int GRID_Z_MAX  = 64;
	localparam int COUNT_WIDTH = 24;

	localparam int X_BITS    = $clog2(GRID_X_MAX);
	localparam int Y_BITS    = $clog2(GRID_Y_MAX);
	localparam int Z_BITS    = $clog2(GRID_Z_MAX);
	localparam int ADDR_BITS = X_BITS + Y_BITS + Z_BITS;
	localparam int CELLS     = 1 << ADDR_BITS;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
	localparam int ENTRY_W = 2 * COUNT_WIDTH;

	localparam int COORD_W = 24;
	localparam int INV_W   = 16;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int PROD_W  = DIFF_W + INV_W + 1;
	localparam int FRAC_W  = 24;
	localparam int IDX_W   = PROD_W - FRAC_W;
	localparam int LIM_W   = 11;

	localparam int CFG_DATA_W  = 24;
	localparam int CFG_INDEX_W = 3;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ORIGIN_X     = 3'd0,
		REG_ORIGIN_Y     = 3'd1,
		REG_ORIGIN_Z     = 3'd2,
		REG_INVERSE_CELL = 3'd3,
		REG_CELLS_X      = 3'd4,
		REG_CELLS_Y      = 3'd5,
		REG_CELLS_Z      = 3'd6
	} reg_idx_e;

	typedef enum logic {
		OP_ADD   = 1'b0,
		OP_QUERY = 1'b1
	} op_e;

	typedef enum logic {
		ST_CLEAR = 1'b0,
		ST_RUN   = 1'b1
	} st_e;

	typedef struct packed {
		logic signed [COORD_W-1:0] origin_x;
		logic signed [COORD_W-1:0] origin_y;
		logic signed [COORD_W-1:0] origin_z;
		logic [INV_W-1:0]          inverse_cell;
		logic [7:0]                cells_x;
		logic [6:0]                cells_y;
		logic [6:0]                cells_z;
	} cfg_t;

	typedef struct packed {
		op_e                       operation;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
		logic                      first_half;
		logic [6:0]                query_x;
		logic [5:0]                query_y;
		logic [5:0]                query_z;
	} cmd_t;

	typedef struct packed {
		logic                   in_grid;
		logic [6:0]             bin_x;
		logic [5:0]             bin_y;
		logic [5:0]             bin_z;
		logic [COUNT_WIDTH-1:0] early_count;
		logic [COUNT_WIDTH-1:0] total_count;
		logic                   keep_cell;
	} rsp_t;

	typedef struct packed {
		logic              valid;
		op_e               operation;
		logic              first_half;
		logic              access;
		logic              in_grid;
		logic [X_BITS-1:0] bin_x;
		logic [Y_BITS-1:0] bin_y;
		logic [Z_BITS-1:0] bin_z;
	} req_t;

endpackage

// ----- src/voxel_density_histogram_filter_top.sv -----
// ----------------------------------------------------------------------------
// voxel_density_histogram_filter_top: voxel histogram with density filter
// Bins sample points into a voxel grid of early and late counts, and answers
// read-and-clear queries with a density-ratio keep flag.
// ----------------------------------------------------------------------------
//   Channel   Ports                        Handshake
//   command   start, busy, cmd             taken when start is high, busy low
//   result    done, rsp                    one cycle per transaction, no stall
//   config    cfg_we, cfg_index, cfg_data  written at every edge with cfg_we
//
// One transaction is taken per cycle while busy is low. Its result strobe
// follows three quantizer stages, then the count memory read and the
// write back. A forwarding register covers back-to-back hits on one voxel.
// After reset, busy stays high while the clearing pass zeroes all 524288
// entries of the count memory one entry per cycle. The receiver cannot stall.
// ----------------------------------------------------------------------------
module voxel_density_histogram_filter_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  vdhf_pkg::cmd_t                      cmd,
	output logic                                done,
	output vdhf_pkg::rsp_t                      rsp,
	input  logic                                cfg_we,
	input  logic [vdhf_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [vdhf_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import vdhf_pkg::*;

	cfg_t cfg_q;
	req_t req;
	logic accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x     <= -24'sd327680;
			cfg_q.origin_y     <= -24'sd196608;
			cfg_q.origin_z     <= -24'sd196608;
			cfg_q.inverse_cell <= 16'd2560;
			cfg_q.cells_x      <= 8'd100;
			cfg_q.cells_y      <= 7'd60;
			cfg_q.cells_z      <= 7'd60;
		end else if (cfg_we) begin
			unique case (reg_idx_e'(cfg_index))
				REG_ORIGIN_X:     cfg_q.origin_x     <= $signed(cfg_data);
				REG_ORIGIN_Y:     cfg_q.origin_y     <= $signed(cfg_data);
				REG_ORIGIN_Z:     cfg_q.origin_z     <= $signed(cfg_data);
				REG_INVERSE_CELL: cfg_q.inverse_cell <= cfg_data[INV_W-1:0];
				REG_CELLS_X:      cfg_q.cells_x      <= cfg_data[7:0];
				REG_CELLS_Y:      cfg_q.cells_y      <= cfg_data[6:0];
				REG_CELLS_Z:      cfg_q.cells_z      <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	assign accept = start && !busy;

	vdhf_quant u_quant (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (accept),
		.cmd    (cmd),
		.cfg    (cfg_q),
		.req    (req)
	);

	vdhf_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

endmodule

// ----- src/vdhf_quant.sv -----
// ----------------------------------------------------------------------------
// vdhf_quant: three-stage voxel quantizer
// Subtracts the grid origin, scales by the inverse cell edge and floors each
// axis, then checks the indices against the grid in use.
// ----------------------------------------------------------------------------
module vdhf_quant (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid,
	input  vdhf_pkg::cmd_t cmd,
	input  vdhf_pkg::cfg_t cfg,
	output vdhf_pkg::req_t req
);
	import vdhf_pkg::*;

	logic                     valid_s1, valid_s2;
	cmd_t                     cmd_s1, cmd_s2;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1, dz_s1;
	logic signed [PROD_W-1:0] px_s2, py_s2, pz_s2;
	logic signed [INV_W:0]    inv_s;
	logic [LIM_W-1:0]         lim_x, lim_y, lim_z;
	logic                     ok_x, ok_y, ok_z, q_ok;
	req_t                     req_d, req_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1 <= cmd;
		dx_s1  <= DIFF_W'(cmd.coord_x) - DIFF_W'(cfg.origin_x);
		dy_s1  <= DIFF_W'(cmd.coord_y) - DIFF_W'(cfg.origin_y);
		dz_s1  <= DIFF_W'(cmd.coord_z) - DIFF_W'(cfg.origin_z);
		cmd_s2 <= cmd_s1;
		px_s2  <= PROD_W'(dx_s1) * PROD_W'(inv_s);
		py_s2  <= PROD_W'(dy_s1) * PROD_W'(inv_s);
		pz_s2  <= PROD_W'(dz_s1) * PROD_W'(inv_s);
	end

	assign inv_s = $signed({1'b0, cfg.inverse_cell});

	assign lim_x = (LIM_W'(cfg.cells_x) > LIM_W'(GRID_X_MAX)) ? LIM_W'(GRID_X_MAX)
		: LIM_W'(cfg.cells_x);
	assign lim_y = (LIM_W'(cfg.cells_y) > LIM_W'(GRID_Y_MAX)) ? LIM_W'(GRID_Y_MAX)
		: LIM_W'(cfg.cells_y);
	assign lim_z = (LIM_W'(cfg.cells_z) > LIM_W'(GRID_Z_MAX)) ? LIM_W'(GRID_Z_MAX)
		: LIM_W'(cfg.cells_z);

	assign ok_x = !px_s2[PROD_W-1] && (px_s2[PROD_W-1:FRAC_W] < IDX_W'(lim_x));
	assign ok_y = !py_s2[PROD_W-1] && (py_s2[PROD_W-1:FRAC_W] < IDX_W'(lim_y));
	assign ok_z = !pz_s2[PROD_W-1] && (pz_s2[PROD_W-1:FRAC_W] < IDX_W'(lim_z));

	assign q_ok = (32'(cmd_s2.query_x) < GRID_X_MAX) && (32'(cmd_s2.query_y) < GRID_Y_MAX)
		&& (32'(cmd_s2.query_z) < GRID_Z_MAX);

	always_comb begin
		req_d            = '0;
		req_d.valid      = valid_s2;
		req_d.operation  = cmd_s2.operation;
		req_d.first_half = cmd_s2.first_half;
		if (cmd_s2.operation == OP_ADD) begin
			req_d.in_grid = ok_x && ok_y && ok_z;
			req_d.access  = req_d.in_grid;
			if (req_d.in_grid) begin
				req_d.bin_x = px_s2[FRAC_W +: X_BITS];
				req_d.bin_y = py_s2[FRAC_W +: Y_BITS];
				req_d.bin_z = pz_s2[FRAC_W +: Z_BITS];
			end
		end else begin
			req_d.access = q_ok;
			req_d.bin_x  = X_BITS'(cmd_s2.query_x);
			req_d.bin_y  = Y_BITS'(cmd_s2.query_y);
			req_d.bin_z  = Z_BITS'(cmd_s2.query_z);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s3 <= '0;
		end else begin
			req_s3 <= req_d;
		end
	end

	assign req = req_s3;

endmodule

// ----- src/vdhf_store.sv -----
// ----------------------------------------------------------------------------
// vdhf_store: count table with read-modify-write and clearing pass
// Holds the early and late count of every voxel in one synchronous memory,
// clears it after reset, then updates or reads and clears one entry per cycle.
// ----------------------------------------------------------------------------
module vdhf_store (
	input  logic           clk,
	input  logic           arst_n,
	input  vdhf_pkg::req_t req,
	output logic           busy,
	output logic           done,
	output vdhf_pkg::rsp_t rsp
);
	import vdhf_pkg::*;

	logic [ENTRY_W-1:0]   cell_mem_q [CELLS];
	st_e                  st_q, st_d;
	logic [ADDR_BITS-1:0] clr_cnt_q;
	logic                 clr_we;
	logic [ADDR_BITS-1:0] rd_addr, wr_addr, addr_s4;
	logic                 wr_en;
	logic [ENTRY_W-1:0]   wr_data, rd_data_s4, entry, new_entry;
	req_t                 req_s4;
	logic                 fwd_valid_q;
	logic [ADDR_BITS-1:0] fwd_addr_q;
	logic [ENTRY_W-1:0]   fwd_data_q;
	logic [COUNT_WIDTH-1:0] early, late, total;
	logic [COUNT_WIDTH:0]   sum;
	logic [COUNT_WIDTH+2:0] five_t, eight_e;
	logic                 s4_we;
	rsp_t                 rsp_d, rsp_q;
	logic                 done_q;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_CLEAR: begin
				if (clr_cnt_q == ADDR_BITS'(CELLS - 1)) begin
					st_d = ST_RUN;
				end
			end
			ST_RUN: st_d = ST_RUN;
			default: st_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		busy   = 1'b0;
		clr_we = 1'b0;
		unique case (st_q)
			ST_CLEAR: begin
				busy   = 1'b1;
				clr_we = 1'b1;
			end
			ST_RUN: begin
				busy   = 1'b0;
				clr_we = 1'b0;
			end
			default: begin
				busy   = 1'b1;
				clr_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			st_q <= st_d;
			if (clr_we) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	assign rd_addr = {req.bin_z, req.bin_y, req.bin_x};
	assign addr_s4 = {req_s4.bin_z, req_s4.bin_y, req_s4.bin_x};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			cell_mem_q[wr_addr] <= wr_data;
		end
		if (req.valid && req.access) begin
			rd_data_s4 <= cell_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s4 <= '0;
		end else begin
			req_s4 <= req;
		end
	end

	// The registered read data misses a write made at the same edge as the read.
	assign entry = (fwd_valid_q && fwd_addr_q == addr_s4) ? fwd_data_q : rd_data_s4;
	assign early = entry[ENTRY_W-1:COUNT_WIDTH];
	assign late  = entry[COUNT_WIDTH-1:0];
	assign sum   = {1'b0, early} + {1'b0, late};
	assign total = sum[COUNT_WIDTH] ? COUNT_MAX : sum[COUNT_WIDTH-1:0];
	assign five_t  = {total, 2'b00} + (COUNT_WIDTH+3)'(total);
	assign eight_e = {early, 3'b000};

	always_comb begin
		new_entry = '0;
		if (req_s4.operation == OP_ADD) begin
			new_entry = entry;
			if (req_s4.first_half) begin
				if (early != COUNT_MAX) begin
					new_entry[ENTRY_W-1:COUNT_WIDTH] = early + 1'b1;
				end
			end else begin
				if (late != COUNT_MAX) begin
					new_entry[COUNT_WIDTH-1:0] = late + 1'b1;
				end
			end
		end
	end

	assign s4_we = req_s4.valid && req_s4.access;

	always_comb begin
		if (clr_we) begin
			wr_en   = 1'b1;
			wr_addr = clr_cnt_q;
			wr_data = '0;
		end else begin
			wr_en   = s4_we;
			wr_addr = addr_s4;
			wr_data = new_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (s4_we && !clr_we) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s4_we) begin
			fwd_addr_q <= addr_s4;
			fwd_data_q <= new_entry;
		end
	end

	always_comb begin
		rsp_d         = '0;
		rsp_d.in_grid = req_s4.in_grid;
		rsp_d.bin_x   = 7'(req_s4.bin_x);
		rsp_d.bin_y   = 6'(req_s4.bin_y);
		rsp_d.bin_z   = 6'(req_s4.bin_z);
		if (req_s4.operation == OP_QUERY && req_s4.access) begin
			rsp_d.early_count = early;
			rsp_d.total_count = total;
			rsp_d.keep_cell   = (total != '0) && (five_t >= eight_e);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= req_s4.valid;
		end
	end

	always_ff @(posedge clk) begin
		rsp_q <= rsp_d;
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	a_no_work_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_CLEAR |-> !req_s4.valid && !req.valid)
		else $error("Transaction in flight during the clearing pass.");

	a_add_no_counts: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && rsp_q.in_grid |-> rsp_q.total_count == '0 && !rsp_q.keep_cell)
		else $error("Add result carries counts.");

	a_total_covers_early: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> rsp_q.total_count >= rsp_q.early_count)
		else $error("Total count below early count.");

	a_keep_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && rsp_q.keep_cell |-> rsp_q.total_count != '0)
		else $error("Kept cell with zero total.");

	a_result_follows_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_s4.valid |=> done_q)
		else $error("Result strobe missing after a transaction.");

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for the voxel density histogram filter
// Directed commands at the reset grid settings come first, and then random
// sample and query traffic under several grid settings, including the
// extremes. Each result is checked field by field against a typed directed
// row's values or else a cycle-free model of the count table in the bench.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import vdhf_pkg::*;

	localparam int QUIET_LIMIT = 4 * CELLS;
	localparam int OX = -327680;
	localparam int OY = -196608;

	typedef struct {
		cmd_t c;
		bit   typed;
		rsp_t r;
	} directed_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	cmd_t cmd;
	logic done;
	rsp_t rsp;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	cfg_t active_cfg = '{origin_x: OX, origin_y: OY, origin_z: OY, inverse_cell: 2560,
		cells_x: 100, cells_y: 60, cells_z: 60};
	bit [COUNT_WIDTH-1:0] early_tally [CELLS];
	bit [COUNT_WIDTH-1:0] late_tally [CELLS];
	int unsigned hit_cells[$];
	logic signed [COORD_W-1:0] recent_x, recent_y, recent_z;
	rsp_t pending_rsp[$];
	directed_t directed[$];
	int errors = 0;
	int quiet = 0;
	int idle_pct = 8;

	voxel_density_histogram_filter_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int unsigned clip(int unsigned n, int unsigned top);
		return n < top ? n : top;
	endfunction

	function automatic bit locate(logic signed [COORD_W-1:0] coord,
			logic signed [COORD_W-1:0] org, int unsigned span, output int unsigned idx);
		longint p;
		idx = 0;
		p = (longint'(coord) - longint'(org)) * longint'(active_cfg.inverse_cell);
		if (p < 0 || (p >>> 24) >= span)
			return 1'b0;
		idx = int'(p >>> 24);
		return 1'b1;
	endfunction

	function automatic rsp_t histogram_response(cmd_t c);
		rsp_t o;
		int unsigned ix, iy, iz, slot;
		longint e, sum;
		o = '0;
		if (c.operation == OP_ADD) begin
			if (locate(c.coord_x, active_cfg.origin_x, clip(active_cfg.cells_x, GRID_X_MAX), ix)
					&& locate(c.coord_y, active_cfg.origin_y,
						clip(active_cfg.cells_y, GRID_Y_MAX), iy)
					&& locate(c.coord_z, active_cfg.origin_z,
						clip(active_cfg.cells_z, GRID_Z_MAX), iz)) begin
				slot = ix + iy * GRID_X_MAX + iz * GRID_X_MAX * GRID_Y_MAX;
				if (c.first_half) begin
					if (early_tally[slot] != COUNT_MAX)
						early_tally[slot] = early_tally[slot] + 1'b1;
				end else begin
					if (late_tally[slot] != COUNT_MAX)
						late_tally[slot] = late_tally[slot] + 1'b1;
				end
				o.in_grid = 1'b1;
				o.bin_x = 7'(ix);
				o.bin_y = 6'(iy);
				o.bin_z = 6'(iz);
				hit_cells.insert(hit_cells.size(), slot);
				if (hit_cells.size() > 48)
					void'(hit_cells.pop_front());
			end
		end else begin
			o.bin_x = c.query_x;
			o.bin_y = c.query_y;
			o.bin_z = c.query_z;
			slot = c.query_x + c.query_y * GRID_X_MAX + c.query_z * GRID_X_MAX * GRID_Y_MAX;
			e = longint'(early_tally[slot]);
			sum = e + longint'(late_tally[slot]);
			if (sum > longint'(COUNT_MAX))
				sum = longint'(COUNT_MAX);
			o.early_count = COUNT_WIDTH'(e);
			o.total_count = COUNT_WIDTH'(sum);
			o.keep_cell = sum != 0 && 5 * sum >= 8 * e;
			early_tally[slot] = '0;
			late_tally[slot] = '0;
		end
		return o;
	endfunction

	function automatic cmd_t add_cmd(int x, int y, int z, bit fh);
		cmd_t c;
		c = '0;
		c.operation = OP_ADD;
		c.coord_x = COORD_W'(x);
		c.coord_y = COORD_W'(y);
		c.coord_z = COORD_W'(z);
		c.first_half = fh;
		return c;
	endfunction

	function automatic cmd_t query_cmd(int qx, int qy, int qz);
		cmd_t c;
		c = '0;
		c.operation = OP_QUERY;
		c.query_x = 7'(qx);
		c.query_y = 6'(qy);
		c.query_z = 6'(qz);
		return c;
	endfunction

	function automatic rsp_t rsp_of(bit g, int bx, int by, int bz, int e, int t, bit k);
		rsp_t r;
		r.in_grid = g;
		r.bin_x = 7'(bx);
		r.bin_y = 6'(by);
		r.bin_z = 6'(bz);
		r.early_count = COUNT_WIDTH'(e);
		r.total_count = COUNT_WIDTH'(t);
		r.keep_cell = k;
		return r;
	endfunction

	function automatic void add_row(cmd_t c, bit typed, rsp_t r);
		directed_t row;
		row.c = c;
		row.typed = typed;
		row.r = r;
		directed.insert(directed.size(), row);
	endfunction

	// Aims at the grid on one axis, with a margin past its far edge.
	function automatic logic signed [COORD_W-1:0] aim_axis(logic signed [COORD_W-1:0] org,
			int unsigned cells, int unsigned top);
		longint span, v;
		int unsigned n;
		n = clip(cells, top);
		if (n == 0 || active_cfg.inverse_cell == 0)
			span = longint'(1) << 20;
		else
			span = ((longint'(n) << 24) + active_cfg.inverse_cell - 1) / active_cfg.inverse_cell;
		span = span + span / 8 + 2;
		v = longint'(org) - 2 + longint'($urandom) % span;
		if (v > 8388607)
			v = 8388607;
		if (v < -8388608)
			v = -8388608;
		return v[COORD_W-1:0];
	endfunction

	function automatic cmd_t next_command();
		cmd_t c;
		logic [3*32-1:0] raw;
		int unsigned pick, slot;
		raw = {$urandom, $urandom, $urandom};
		c = raw[$bits(cmd_t)-1:0];
		pick = $urandom_range(99);
		if (pick < 10)
			return c;
		if (pick < 68) begin
			c.operation = OP_ADD;
			if ($urandom_range(3) != 0) begin
				recent_x = aim_axis(active_cfg.origin_x, active_cfg.cells_x, GRID_X_MAX);
				recent_y = aim_axis(active_cfg.origin_y, active_cfg.cells_y, GRID_Y_MAX);
				recent_z = aim_axis(active_cfg.origin_z, active_cfg.cells_z, GRID_Z_MAX);
			end
			c.coord_x = recent_x;
			c.coord_y = recent_y;
			c.coord_z = recent_z;
		end else begin
			c.operation = OP_QUERY;
			if (hit_cells.size() > 0 && $urandom_range(9) < 8) begin
				if ($urandom_range(4) == 0)
					slot = hit_cells[$];
				else
					slot = hit_cells[$urandom_range(hit_cells.size() - 1)];
				c.query_x = 7'(slot % GRID_X_MAX);
				c.query_y = 6'((slot / GRID_X_MAX) % GRID_Y_MAX);
				c.query_z = 6'(slot / (GRID_X_MAX * GRID_Y_MAX));
			end
		end
		return c;
	endfunction

	task automatic post_command(input cmd_t c, input bit typed, input rsp_t r);
		rsp_t model;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		model = histogram_response(c);
		pending_rsp.insert(pending_rsp.size(), typed ? r : model);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic load_config(input cfg_t c);
		reg_idx_e r;
		logic [CFG_DATA_W-1:0] v;
		r = r.first();
		do begin
			case (r)
				REG_ORIGIN_X:     v = c.origin_x;
				REG_ORIGIN_Y:     v = c.origin_y;
				REG_ORIGIN_Z:     v = c.origin_z;
				REG_INVERSE_CELL: v = CFG_DATA_W'(c.inverse_cell);
				REG_CELLS_X:      v = CFG_DATA_W'(c.cells_x);
				REG_CELLS_Y:      v = CFG_DATA_W'(c.cells_y);
				default:          v = CFG_DATA_W'(c.cells_z);
			endcase
			cfg_we <= 1'b1;
			cfg_index <= r;
			cfg_data <= v;
			@(posedge clk);
			r = r.next();
		end while (r != r.first());
		cfg_we <= 1'b0;
		active_cfg = c;
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("result with no transaction outstanding: %h", rsp);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.in_grid !== want.in_grid || rsp.bin_x !== want.bin_x
						|| rsp.bin_y !== want.bin_y || rsp.bin_z !== want.bin_z
						|| rsp.early_count !== want.early_count
						|| rsp.total_count !== want.total_count
						|| rsp.keep_cell !== want.keep_cell) begin
					errors++;
					if (errors <= 10)
						$display("mismatch (expected/actual): in_grid %0d/%0d",
							want.in_grid, rsp.in_grid,
							" bin %0d,%0d,%0d/%0d,%0d,%0d", want.bin_x, want.bin_y,
							want.bin_z, rsp.bin_x, rsp.bin_y, rsp.bin_z,
							" early %0d/%0d total %0d/%0d", want.early_count,
							rsp.early_count, want.total_count, rsp.total_count,
							" keep %0d/%0d", want.keep_cell, rsp.keep_cell);
				end
			end
		end
	end

	// The clearing pass after reset is the longest quiet stretch of a good run.
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		cfg_t setups [7];
		int phase_len [7];
		int sent;
		arst_n <= 1'b0;
		start <= 1'b0;
		cmd <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		setups[0] = active_cfg;
		setups[1] = '{origin_x: 0, origin_y: 0, origin_z: 0, inverse_cell: 256,
			cells_x: 128, cells_y: 64, cells_z: 64};
		setups[2] = '{origin_x: -8388608, origin_y: -8388608, origin_z: -8388608,
			inverse_cell: 65535, cells_x: 255, cells_y: 127, cells_z: 127};
		setups[3] = '{origin_x: 8388607, origin_y: 8388607, origin_z: 8388607,
			inverse_cell: 1, cells_x: 1, cells_y: 1, cells_z: 1};
		setups[4] = '{origin_x: -1000000, origin_y: 500000, origin_z: -3, inverse_cell: 0,
			cells_x: 50, cells_y: 40, cells_z: 30};
		setups[5] = '{origin_x: OY, origin_y: OY, origin_z: OY, inverse_cell: 3000,
			cells_x: 0, cells_y: 64, cells_z: 63};
		setups[6] = '{origin_x: -1193046, origin_y: 1234567, origin_z: -4000000,
			inverse_cell: 1234, cells_x: 37, cells_y: 21, cells_z: 9};
		phase_len = '{400, 300, 300, 150, 100, 100, 530};
		recent_x = OX;
		recent_y = OY;
		recent_z = OY;

		add_row(query_cmd(0, 0, 0), 1'b1, rsp_of(0, 0, 0, 0, 0, 0, 0));
		add_row(query_cmd(127, 63, 63), 1'b1, rsp_of(0, 127, 63, 63, 0, 0, 0));
		add_row(add_cmd(OX, OY, OY, 1), 1'b1, rsp_of(1, 0, 0, 0, 0, 0, 0));
		add_row(query_cmd(0, 0, 0), 1'b1, rsp_of(0, 0, 0, 0, 1, 1, 0));
		add_row(add_cmd(OX, OY, OY, 1), 1'b1, rsp_of(1, 0, 0, 0, 0, 0, 0));
		add_row(add_cmd(OX, OY, OY, 0), 1'b1, rsp_of(1, 0, 0, 0, 0, 0, 0));
		add_row(add_cmd(OX, OY, OY, 0), 1'b1, rsp_of(1, 0, 0, 0, 0, 0, 0));
		add_row(query_cmd(0, 0, 0), 1'b1, rsp_of(0, 0, 0, 0, 1, 3, 1));
		add_row(query_cmd(0, 0, 0), 1'b1, rsp_of(0, 0, 0, 0, 0, 0, 0));
		add_row(add_cmd(-8388608, OY, OY, 1), 1'b1, rsp_of(0, 0, 0, 0, 0, 0, 0));
		add_row(add_cmd(8388607, OY, OY, 0), 1'b1, rsp_of(0, 0, 0, 0, 0, 0, 0));
		add_row(add_cmd(OX, 8388607, OY, 1), 1'b1, rsp_of(0, 0, 0, 0, 0, 0, 0));
		add_row(add_cmd(OX, OY, OY - 1, 0), 1'b1, rsp_of(0, 0, 0, 0, 0, 0, 0));
		add_row(add_cmd(OX + 655360, OY, OY, 1), 1'b1, rsp_of(0, 0, 0, 0, 0, 0, 0));
		add_row(add_cmd(0, 0, 0, 1), 1'b0, rsp_of(0, 0, 0, 0, 0, 0, 0));
		add_row(add_cmd(0, 0, 0, 0), 1'b0, rsp_of(0, 0, 0, 0, 0, 0, 0));
		add_row(add_cmd(0, 0, 0, 1), 1'b0, rsp_of(0, 0, 0, 0, 0, 0, 0));
		add_row(query_cmd(50, 30, 30), 1'b0, rsp_of(0, 0, 0, 0, 0, 0, 0));
		add_row(add_cmd(OX + 652083, OY + 393215, OY + 393215, 0), 1'b0,
			rsp_of(0, 0, 0, 0, 0, 0, 0));
		add_row(query_cmd(99, 59, 59), 1'b0, rsp_of(0, 0, 0, 0, 0, 0, 0));
		add_row(query_cmd(50, 30, 30), 1'b0, rsp_of(0, 0, 0, 0, 0, 0, 0));
		add_row(add_cmd(-1, -1, -1, 1), 1'b0, rsp_of(0, 0, 0, 0, 0, 0, 0));
		add_row(query_cmd(127, 0, 63), 1'b0, rsp_of(0, 0, 0, 0, 0, 0, 0));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			post_command(directed[i].c, directed[i].typed, directed[i].r);

		sent = 0;
		for (int p = 0; p < 7; p++) begin
			if (p > 0) begin
				drain();
				load_config(setups[p]);
			end
			repeat (phase_len[p]) begin
				idle_pct = sent < 630 ? 8 : (sent < 1260 ? 87 : 0);
				post_command(next_command(), 1'b0, '0);
				sent++;
			end
		end
		drain();

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- voxel_density_histogram_filter_top.f -----
src/vdhf_pkg.sv
src/vdhf_quant.sv
src/vdhf_store.sv
src/voxel_density_histogram_filter_top.sv
bench/tb.sv
